>>> sv/bdq_pkg.sv
// Shared types and constants for the bounded deque.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DATA_W = 32;

  // Element reported by a dump of an empty queue.
  localparam logic signed [DATA_W-1:0] EMPTY_ELEMENT = -32'sd1;

  // Request codes; 6 and 7 are unused and ignored.
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP_FWD   = 3'd4,
    CMD_DUMP_REV   = 3'd5
  } cmd_t;

  // Tag that travels beside a slot read, lined up with the read data.
  typedef struct packed {
    logic valid;
    logic last;
    logic empty;
    logic overflow;
  } tag_t;

endpackage

>>> sv/bounded_deque.sv
// Top level of the bounded deque: control, slot memory and result stage.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a ring of CAPACITY
// slots. A request is taken at a rising edge where start is high and busy is
// low. Push and pop requests give no result, so they can be issued back to
// back. A dump keeps the block until its last slot read (busy is high during
// every read but the last) because the slot memory has one read port and
// gives one element per cycle; its results pass the dump state and then the
// registered slot read, one per cycle, in order, with last on the final one.
// A dump of an empty queue gives one result in the cycle after the request:
// element -1, empty_marker and last set. Each result is shown for exactly one
// cycle with result_valid high; the receiver cannot hold it off, so it must
// take every result as it comes. overflow_seen is the sticky dropped-push
// flag as it stood when that element was read. Pops on an empty queue and
// unused command codes are accepted and ignored. No clearing pass is needed
// after reset.
module bounded_deque #(
  parameter int CAPACITY = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       command,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  output logic                             result_valid,
  output logic signed [bdq_pkg::DATA_W-1:0] element,
  output logic                             empty_marker,
  output logic                             last,
  output logic                             overflow_seen
);
  import bdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  tag_t              tag;
  tag_t              tag_q;

  bdq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .value  (value),
    .busy   (busy),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .tag    (tag)
  );

  bdq_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Tag is registered alongside the slot read so it lines up with rdata.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag;
    end
  end

  assign result_valid  = tag_q.valid;
  assign element       = tag_q.empty ? EMPTY_ELEMENT : signed'(rdata);
  assign empty_marker  = tag_q.empty;
  assign last          = tag_q.last;
  assign overflow_seen = tag_q.overflow;

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_marker |-> last)
    else $error("empty result not marked last");

  a_empty_from_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_marker |-> !busy && !$past(busy))
    else $error("empty result during a dump");

  a_result_after_dump: assert property (@(posedge clk) disable iff (rst)
    busy |=> result_valid && !empty_marker)
    else $error("no element while dumping");

endmodule

>>> sv/bdq_ram.sv
// Slot store of the deque: one write port, one registered read port.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bdq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [bdq_pkg::DATA_W-1:0] rdata
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // read sees the old entry when both ports hit the same slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/bdq_ctrl.sv
// Deque control: front index, fill count, overflow flag and dump sequencer.
`timescale 1ns / 1ps

module bdq_ctrl #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [2:0]                       command,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  output logic                             busy,
  output logic                             we,
  output logic [AW-1:0]                    waddr,
  output logic [bdq_pkg::DATA_W-1:0]        wdata,
  output logic                             re,
  output logic [AW-1:0]                    raddr,
  output bdq_pkg::tag_t                    tag
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL      = CW'(CAPACITY);
  localparam logic [AW:0]   RING_SIZE = (AW+1)'(CAPACITY);
  localparam logic [CW-1:0] ONE       = CW'(1);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  // base + off with both below CAPACITY: one compare and subtract
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= RING_SIZE) begin
      sum = sum - RING_SIZE;
    end
    return sum[AW-1:0];
  endfunction

  state_t        state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] rem, rem_next;
  logic          reverse, reverse_next;

  cmd_t          cmd;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] tail_slot;

  assign cmd       = cmd_t'(command);
  assign busy      = (state == ST_DUMP) && (rem != ONE);
  assign accept    = start && !busy;
  assign is_full   = (count == FULL);
  assign is_empty  = (count == '0);
  assign count_m1  = count - ONE;
  assign back_slot = ring_add(front, count_m1[AW-1:0]);
  assign tail_slot = ring_add(front, count[AW-1:0]);
  assign wdata     = value;

  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    overflow_next = overflow;
    ptr_next      = ptr;
    rem_next      = rem;
    reverse_next  = reverse;
    we            = 1'b0;
    waddr         = tail_slot;
    re            = 1'b0;
    raddr         = ptr;
    tag           = '0;

    // one slot read per cycle while dumping
    unique case (state)
      ST_IDLE: begin
      end
      ST_DUMP: begin
        re           = 1'b1;
        tag.valid    = 1'b1;
        tag.last     = (rem == ONE);
        tag.overflow = overflow;
        ptr_next     = reverse ? slot_dec(ptr) : slot_inc(ptr);
        rem_next     = rem - ONE;
        if (rem == ONE) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            overflow_next = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = slot_dec(front);
            front_next = slot_dec(front);
            count_next = count + ONE;
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            overflow_next = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = tail_slot;
            count_next = count + ONE;
          end
        end
        CMD_POP_FRONT: begin
          if (!is_empty) begin
            front_next = slot_inc(front);
            count_next = count_m1;
          end
        end
        CMD_POP_BACK: begin
          if (!is_empty) begin
            count_next = count_m1;
          end
        end
        CMD_DUMP_FWD, CMD_DUMP_REV: begin
          if (is_empty) begin
            // never overlaps a dump read: count is nonzero during a dump
            tag.valid    = 1'b1;
            tag.last     = 1'b1;
            tag.empty    = 1'b1;
            tag.overflow = overflow;
          end else begin
            state_next   = ST_DUMP;
            rem_next     = count;
            reverse_next = (cmd == CMD_DUMP_REV);
            ptr_next     = (cmd == CMD_DUMP_REV) ? back_slot : front;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      front    <= '0;
      count    <= '0;
      overflow <= 1'b0;
      ptr      <= '0;
      rem      <= '0;
      reverse  <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      overflow <= overflow_next;
      ptr      <= ptr_next;
      rem      <= rem_next;
      reverse  <= reverse_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count above capacity");

  a_busy_dump: assert property (@(posedge clk) disable iff (rst)
    busy |-> (state == ST_DUMP) && (rem > ONE))
    else $error("busy outside a dump");

  a_last_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) && (rem == ONE) |=> (state == ST_IDLE) || (rem == count))
    else $error("dump did not end after its last read");

  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    accept && is_full && ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK))
    |=> overflow && (count == FULL))
    else $error("dropped push did not set overflow");

  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    accept && !is_empty && ((cmd == CMD_DUMP_FWD) || (cmd == CMD_DUMP_REV))
    |=> (state == ST_DUMP) && (rem == $past(count)))
    else $error("dump did not start with the fill count");

endmodule

>>> tb/bounded_deque_tb.sv
// Self-checking testbench for the bounded deque: random and directed requests, scoreboard.
`timescale 1ns / 1ps

module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int DEPTH = 32;
  localparam int DW = bdq_pkg::DATA_W;

  // Unused request codes.
  localparam logic [2:0] CMD_RSVD6      = 3'd6;
  localparam logic [2:0] CMD_RSVD7      = 3'd7;

  localparam logic signed [DW-1:0] MAX_VAL = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] MIN_VAL = 32'sh8000_0000;

  // Result cap on the final drain, in cycles.
  localparam int DRAIN_LIMIT = 4000;

  typedef struct packed {
    logic signed [DW-1:0] element;
    logic                 empty_marker;
    logic                 last;
    logic                 overflow_seen;
  } dump_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [2:0]           command;
  logic signed [DW-1:0] value;
  logic                 result_valid;
  logic signed [DW-1:0] element;
  logic                 empty_marker;
  logic                 last;
  logic                 overflow_seen;

  bounded_deque #(.CAPACITY(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .value        (value),
    .result_valid (result_valid),
    .element      (element),
    .empty_marker (empty_marker),
    .last         (last),
    .overflow_seen(overflow_seen)
  );

  // Shadow deque: ring of DEPTH slots, head index, fill count, sticky drop
  // flag. Every accepted request is noted in it; dumps queue their results.
  class deque_scoreboard;
    logic [DW-1:0] ring [DEPTH];
    int unsigned   head;
    int unsigned   count;
    bit            dropped;
    dump_result_t  dump_q[$];
    int            errors;

    function new();
      head    = 0;
      count   = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function int fill();
      return count;
    endfunction

    function int pending();
      return dump_q.size();
    endfunction

    function void note_request(logic [2:0] cmd, logic [DW-1:0] val);
      dump_result_t r;
      int unsigned  off;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            dropped = 1'b1;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = val;
            count++;
          end
        end
        CMD_PUSH_BACK: begin
          if (count >= DEPTH) begin
            dropped = 1'b1;
          end else begin
            ring[(head + count) % DEPTH] = val;
            count++;
          end
        end
        CMD_POP_FRONT: begin
          if (count > 0) begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        CMD_POP_BACK: begin
          if (count > 0) count--;
        end
        CMD_DUMP_FWD, CMD_DUMP_REV: begin
          if (count == 0) begin
            r.element       = bdq_pkg::EMPTY_ELEMENT;
            r.empty_marker  = 1'b1;
            r.last          = 1'b1;
            r.overflow_seen = dropped;
            dump_q.push_back(r);
          end else begin
            for (int i = 0; i < count; i++) begin
              off = (cmd == CMD_DUMP_FWD) ? i : (count - 1 - i);
              r.element       = ring[(head + off) % DEPTH];
              r.empty_marker  = 1'b0;
              r.last          = (i + 1 == count);
              r.overflow_seen = dropped;
              dump_q.push_back(r);
            end
          end
        end
        default: ;  // unused codes leave the state alone
      endcase
    endfunction

    function void check_result(logic signed [DW-1:0] elem, logic emp, logic lst,
                               logic ovf);
      dump_result_t r;
      if (dump_q.size() == 0) begin
        $error("unexpected result: element %0d empty_marker %b last %b overflow_seen %b",
               elem, emp, lst, ovf);
        errors++;
        return;
      end
      r = dump_q.pop_front();
      if (elem !== r.element) begin
        $error("element: expected %0d, got %0d", r.element, elem);
        errors++;
      end
      if (emp !== r.empty_marker) begin
        $error("empty_marker: expected %b, got %b", r.empty_marker, emp);
        errors++;
      end
      if (lst !== r.last) begin
        $error("last: expected %b, got %b", r.last, lst);
        errors++;
      end
      if (ovf !== r.overflow_seen) begin
        $error("overflow_seen: expected %b, got %b", r.overflow_seen, ovf);
        errors++;
      end
    endfunction
  endclass

  deque_scoreboard sb;
  int              idle_pct;

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(12 * 200000);
    $display("status: fail");
    $finish;
  end

  // Monitor: sampled on the rising edge. Results are checked before the
  // request of the same edge is noted, so a stray result can never be
  // matched against the new request's expectations.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(element, empty_marker, last, overflow_seen);
      if (start && !busy) sb.note_request(command, value);
    end
  end

  // Present one request from the falling edge and hold it until taken.
  task automatic issue(input logic [2:0] cmd, input logic signed [DW-1:0] val);
    @(negedge clk);
    start   = 1'b1;
    command = cmd;
    value   = val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender idle with start low; the data lines carry noise meanwhile.
  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start   = 1'b0;
      command = $urandom;
      value   = $urandom;
    end
  endtask

  // Stop sending until every queued dump result has come back.
  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return -1;
      1:       return 0;
      2:       return MAX_VAL;
      3:       return MIN_VAL;
      default: return $urandom;
    endcase
  endfunction

  // Issue, then maybe leave a gap so idles land on every dump phase.
  task automatic send(input logic [2:0] cmd, input logic signed [DW-1:0] val);
    issue(cmd, val);
    while ($urandom_range(99) < idle_pct) idle(1);
  endtask

  task automatic random_request();
    int          r;
    logic [2:0]  cmd;
    r = $urandom_range(99);
    if (r < 30)      cmd = CMD_PUSH_FRONT;
    else if (r < 60) cmd = CMD_PUSH_BACK;
    else if (r < 72) cmd = CMD_POP_FRONT;
    else if (r < 84) cmd = CMD_POP_BACK;
    else if (r < 91) cmd = CMD_DUMP_FWD;
    else if (r < 97) cmd = CMD_DUMP_REV;
    else             cmd = $urandom_range(1) ? CMD_RSVD7 : CMD_RSVD6;
    // pops, dumps and unused codes get a random value too, to show it is ignored
    send(cmd, pick_value());
  endtask

  // Empty the deque from random ends, one extra pop on empty, then dump.
  task automatic flush_sequence();
    int n;
    n = sb.fill() + 1;
    repeat (n) send($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
    send(CMD_DUMP_FWD, pick_value());
  endtask

  // Fill to capacity from both ends, push past it, dump both ways.
  task automatic fill_sequence();
    while (sb.fill() < DEPTH)
      send($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
    send(CMD_PUSH_FRONT, pick_value());
    send(CMD_PUSH_BACK, pick_value());
    send(CMD_DUMP_FWD, pick_value());
    send(CMD_DUMP_REV, pick_value());
  endtask

  task automatic random_phase(input int pct, input int n_items);
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) begin
      random_request();
      if (i == n_items / 2) flush_sequence();
    end
  endtask

  initial begin
    int waited;
    sb       = new();
    idle_pct = 0;
    rst      = 1'b1;
    start    = 1'b0;
    command  = CMD_PUSH_FRONT;
    value    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty dumps, pops on empty, extreme values, -1 as data,
    // unused codes, both dump directions, single-element dump.
    send(CMD_DUMP_FWD, 0);
    send(CMD_DUMP_REV, -1);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_PUSH_FRONT, MAX_VAL);
    send(CMD_PUSH_BACK, MIN_VAL);
    send(CMD_PUSH_BACK, -1);
    send(CMD_PUSH_FRONT, 0);
    send(CMD_DUMP_FWD, 0);
    send(CMD_DUMP_REV, 0);
    send(CMD_RSVD6, 32'sh1234_5678);
    send(CMD_RSVD7, -1);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_DUMP_FWD, 0);
    send(CMD_POP_FRONT, 0);
    send(CMD_DUMP_REV, 0);
    send(CMD_POP_BACK, 0);
    send(CMD_DUMP_FWD, 0);
    send(CMD_PUSH_BACK, -1);
    send(CMD_DUMP_REV, 0);
    drain();

    // Sender idles 10 in 100, ends with a full deque and the first overflow.
    random_phase(10, 12);
    fill_sequence();
    drain();

    // Sender idles 82 in 100.
    random_phase(82, 12);
    drain();

    // Back to back.
    random_phase(0, 12);
    fill_sequence();
    flush_sequence();

    // Final drain with a bound, then let the pipe settle.
    idle(1);
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> bounded_deque.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_ctrl.sv
sv/bounded_deque.sv
tb/bounded_deque_tb.sv
